// ----- rtl/clsa_pkg.sv -----
// ----------------------------------------------------------------------------
// clsa_pkg
// Types, widths and codes shared by the class score loss accumulator.
// ----------------------------------------------------------------------------
package clsa_pkg;

   localparam int MAX_CLASSES_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int SCORE_W       = 16;
   localparam int CLASS_W       = 6;
   localparam int LOSS_W        = 48;
   localparam int FRACTION_W    = 8;
   localparam int MAGSUM_W      = 22;
   localparam int MODE_W        = 2;
   localparam int NUM_CLASSES_W = 7;
   localparam int MAGNITUDE_W   = 11;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 11;

   localparam int DIVIDEND_W = LOSS_W + FRACTION_W;
   localparam int DIV_STEPS  = DIVIDEND_W;

   localparam logic [LOSS_W-1:0]     LOSS_MAX     = {LOSS_W{1'b1}};
   localparam logic [MAGSUM_W-1:0]   MAGSUM_MAX   = {MAGSUM_W{1'b1}};
   localparam logic [FRACTION_W-1:0] FRACTION_MAX = {FRACTION_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE             = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_CLASSES      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_MAGNITUDE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [CLASS_W-1:0]        true_class;
   } req_type;

   typedef struct packed {
      logic [LOSS_W-1:0]     loss;
      logic [FRACTION_W-1:0] loss_fraction;
      logic [CLASS_W-1:0]    predicted_class;
      logic                  correct;
      logic                  divide_by_zero;
   } rsp_type;

   // one finished vector handed from the front to the back
   typedef struct packed {
      logic [LOSS_W-1:0]   loss;
      logic [MAGSUM_W-1:0] magnitude;
      logic [CLASS_W-1:0]  predicted_class;
      logic                correct;
      logic                normalized;
   } summary_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_OUTPUT
   } back_state_type;

endpackage

// ----- rtl/class_score_loss_accumulator.sv -----
// ----------------------------------------------------------------------------
// class_score_loss_accumulator
// Squared error loss and argmax over streamed class score vectors.
// ----------------------------------------------------------------------------
//   channel   direction  beat contents
//   req_      in         one class score and the true class
//   rsp_      out        loss, fraction, predicted class, correct, zero flag
//   csr_      in         register index and write data
//
// The front takes one score a cycle unless stalled; a score passes stages
// s1, s2 and s3 before it reaches the loss accumulator. Each finished
// vector goes into a four entry queue. The back takes one vector from the
// queue per result, the next after the output beat; in normalized mode the
// divider runs first (a zero divisor skips it); a stalled receiver adds its
// wait. With the queue full the front stalls at its last pipe stage.
// Reset is synchronous and clears all control and accumulator state.
// ----------------------------------------------------------------------------
module class_score_loss_accumulator #(
   parameter int MAX_CLASSES = clsa_pkg::MAX_CLASSES_DEFAULT,
   parameter int QUEUE_DEPTH = clsa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  clsa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output clsa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [clsa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [clsa_pkg::CSR_DATA_W-1:0]   csr_data
);
   import clsa_pkg::*;

   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [NUM_CLASSES_W-1:0] num_classes_ff, num_classes_in;
   logic [MAGNITUDE_W-1:0]   magnitude_ff, magnitude_in;

   logic        push_valid, push_full, pop, empty;
   summary_type push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in        = mode_ff;
      num_classes_in = num_classes_ff;
      magnitude_in   = magnitude_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:             mode_in        = csr_data[MODE_W-1:0];
            CSR_NUM_CLASSES:      num_classes_in = csr_data[NUM_CLASSES_W-1:0];
            CSR_TARGET_MAGNITUDE: magnitude_in   = csr_data[MAGNITUDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PLAIN;
         num_classes_ff <= NUM_CLASSES_W'(10);
         magnitude_ff   <= MAGNITUDE_W'(64);
      end else begin
         mode_ff        <= mode_in;
         num_classes_ff <= num_classes_in;
         magnitude_ff   <= magnitude_in;
      end
   end

   clsa_front #(
      .MAX_CLASSES(MAX_CLASSES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .mode            (mode_ff),
      .num_classes     (num_classes_ff),
      .target_magnitude(magnitude_ff),
      .push_valid      (push_valid),
      .push_full       (push_full),
      .push_data       (push_data)
   );

   clsa_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_full (push_full),
      .push_data (push_data),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (pop_data)
   );

   clsa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop      (pop),
      .pop_data (pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// ----- rtl/clsa_front.sv -----
// ----------------------------------------------------------------------------
// clsa_front
// Score intake: argmax, magnitude sum and a three stage squared error
// pipeline feeding the saturating loss accumulator.
// ----------------------------------------------------------------------------
module clsa_front #(
   parameter int MAX_CLASSES = clsa_pkg::MAX_CLASSES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  clsa_pkg::req_type                   req_data,
   input  logic [clsa_pkg::MODE_W-1:0]         mode,
   input  logic [clsa_pkg::NUM_CLASSES_W-1:0]  num_classes,
   input  logic [clsa_pkg::MAGNITUDE_W-1:0]    target_magnitude,
   output logic                                push_valid,
   input  logic                                push_full,
   output clsa_pkg::summary_type               push_data
);
   import clsa_pkg::*;

   localparam int PW = $clog2(MAX_CLASSES);
   localparam int NW = $clog2(MAX_CLASSES + 1);
   localparam int LW = (NW > NUM_CLASSES_W) ? NW : NUM_CLASSES_W;
   localparam int CW = (PW > CLASS_W) ? PW : CLASS_W;
   localparam int DW = SCORE_W;
   localparam int SQW = 2 * DW;
   localparam int TW = SQW + PW;
   localparam int SW = ((TW > LOSS_W) ? TW : LOSS_W) + 1;

   // vector state
   logic [PW-1:0]             position_ff, position_in;
   logic [CLASS_W-1:0]        latched_ff, latched_in;
   logic signed [SCORE_W-1:0] best_ff, best_in;
   logic [PW-1:0]             best_class_ff, best_class_in;
   logic [MAGSUM_W-1:0]       mag_ff, mag_in;
   logic [LOSS_W-1:0]         loss_ff, loss_in;

   // pipeline
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                s1_first_ff, s2_first_ff, s3_first_ff;
   logic                s1_last_ff, s2_last_ff, s3_last_ff;
   logic [DW-1:0]       s1_diff_ff;
   logic [PW-1:0]       s1_weight_ff, s2_weight_ff;
   logic [SQW-1:0]      s2_sq_ff;
   logic [TW-1:0]       s3_term_ff;
   summary_type         s1_info_ff, s2_info_ff, s3_info_ff;

   logic                advance, accept, first, last, is_true;
   logic [LW-1:0]       num_ext, n_eff, pos_ext;
   logic [CW-1:0]       latched_ext, best_class_ext;
   logic [DW-1:0]       diff_abs, score_abs;
   logic signed [17:0]  mag_s, expected, diff, diff_neg, diff_full;
   logic [PW-1:0]       weight;
   logic [MAGSUM_W:0]   mag_sum;
   logic [SW-1:0]       loss_sum;
   logic [LOSS_W-1:0]   loss_base;
   summary_type         info;

   assign advance   = !(s3_valid_ff && s3_last_ff && push_full);
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_comb begin
      num_ext = LW'(num_classes);
      if (num_ext < LW'(2)) begin
         n_eff = LW'(2);
      end else if (num_ext > LW'(MAX_CLASSES)) begin
         n_eff = LW'(MAX_CLASSES);
      end else begin
         n_eff = num_ext;
      end
      pos_ext = LW'(position_ff);
      first   = (position_ff == '0);
      last    = ({1'b0, pos_ext} + 1'b1) >= {1'b0, n_eff};

      latched_in = first ? req_data.true_class : latched_ff;
      if (first) begin
         best_in       = req_data.score;
         best_class_in = '0;
      end else if (req_data.score > best_ff) begin
         best_in       = req_data.score;
         best_class_in = position_ff;
      end else begin
         best_in       = best_ff;
         best_class_in = best_class_ff;
      end

      latched_ext    = CW'(latched_in);
      best_class_ext = CW'(best_class_in);
      is_true        = (CW'(position_ff) == latched_ext);

      mag_s     = signed'({7'b0, target_magnitude});
      expected  = is_true ? mag_s : -mag_s;
      diff      = expected - 18'(req_data.score);
      diff_neg  = -diff;
      diff_full = diff[17] ? diff_neg : diff;
      diff_abs  = diff_full[DW-1:0];

      if (mode != MODE_PLAIN && is_true) begin
         weight = PW'(n_eff - LW'(1));
      end else begin
         weight = PW'(1);
      end

      score_abs = req_data.score[SCORE_W-1] ? (~req_data.score + 1'b1) : req_data.score;
      mag_sum   = {1'b0, (first ? '0 : mag_ff)} + (MAGSUM_W + 1)'(score_abs);
      mag_in    = (mag_sum > {1'b0, MAGSUM_MAX}) ? MAGSUM_MAX : mag_sum[MAGSUM_W-1:0];

      position_in = last ? '0 : position_ff + 1'b1;

      info.loss            = '0;
      info.magnitude       = mag_in;
      info.predicted_class = best_class_ext[CLASS_W-1:0];
      info.correct         = (best_class_ext == latched_ext);
      info.normalized      = mode[1];
   end

   // saturating accumulation at the end of the pipe
   always_comb begin
      loss_base = s3_first_ff ? '0 : loss_ff;
      loss_sum  = SW'(loss_base) + SW'(s3_term_ff);
      loss_in   = (loss_sum > SW'(LOSS_MAX)) ? LOSS_MAX : loss_sum[LOSS_W-1:0];
      push_valid = s3_valid_ff && s3_last_ff;
      push_data  = s3_info_ff;
      push_data.loss = loss_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         latched_ff    <= '0;
         best_ff       <= '0;
         best_class_ff <= '0;
         mag_ff        <= '0;
         loss_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            position_ff   <= position_in;
            latched_ff    <= latched_in;
            best_ff       <= best_in;
            best_class_ff <= best_class_in;
            mag_ff        <= mag_in;
         end
         if (advance) begin
            s1_valid_ff <= req_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            if (s3_valid_ff) begin
               loss_ff <= loss_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff  <= first;
         s1_last_ff   <= last;
         s1_diff_ff   <= diff_abs;
         s1_weight_ff <= weight;
         s1_info_ff   <= info;

         s2_first_ff  <= s1_first_ff;
         s2_last_ff   <= s1_last_ff;
         s2_sq_ff     <= s1_diff_ff * s1_diff_ff;
         s2_weight_ff <= s1_weight_ff;
         s2_info_ff   <= s1_info_ff;

         s3_first_ff  <= s2_first_ff;
         s3_last_ff   <= s2_last_ff;
         s3_term_ff   <= TW'(s2_sq_ff) * TW'(s2_weight_ff);
         s3_info_ff   <= s2_info_ff;
      end
   end

endmodule

// ----- rtl/clsa_queue.sv -----
// ----------------------------------------------------------------------------
// clsa_queue
// Small register queue of finished vector summaries between front and back.
// ----------------------------------------------------------------------------
module clsa_queue #(
   parameter int DEPTH = clsa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_full,
   input  clsa_pkg::summary_type push_data,
   input  logic                  pop,
   output logic                  empty,
   output clsa_pkg::summary_type pop_data
);
   import clsa_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   summary_type     entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_full = (count_ff == CNTW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/clsa_back.sv -----
// ----------------------------------------------------------------------------
// clsa_back
// Result stage: optional bit serial normalizing division and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module clsa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   output logic                  pop,
   input  clsa_pkg::summary_type pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output clsa_pkg::rsp_type     rsp_data
);
   import clsa_pkg::*;

   localparam int CNTW = $clog2(DIV_STEPS);

   back_state_type        state_ff, state_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [MAGSUM_W-1:0]   rem_ff, rem_in, div_ff;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   rsp_type               rsp_ff;

   logic                  need_divide, div_done, start, step;
   logic [MAGSUM_W:0]     trial, trial_diff;
   logic                  fits;

   assign need_divide = pop_data.normalized && (pop_data.magnitude != '0);
   assign div_done    = (count_ff == CNTW'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               state_in = need_divide ? BK_DIVIDE : BK_OUTPUT;
            end
         end
         BK_DIVIDE: begin
            if (div_done) begin
               state_in = BK_OUTPUT;
            end
         end
         BK_OUTPUT: begin
            if (rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      start     = 1'b0;
      step      = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop   = !empty;
            start = !empty;
         end
         BK_DIVIDE: step      = 1'b1;
         BK_OUTPUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      fits       = (trial >= {1'b0, div_ff});
      rem_in     = fits ? trial_diff[MAGSUM_W-1:0] : trial[MAGSUM_W-1:0];
      quo_in     = {quo_ff[DIVIDEND_W-2:0], fits};
      count_in   = start ? '0 : count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= count_in;
         rem_ff   <= '0;
         quo_ff   <= {pop_data.loss, {FRACTION_W{1'b0}}};
         div_ff   <= pop_data.magnitude;
         rsp_ff.predicted_class <= pop_data.predicted_class;
         rsp_ff.correct         <= pop_data.correct;
         if (!pop_data.normalized) begin
            rsp_ff.loss           <= pop_data.loss;
            rsp_ff.loss_fraction  <= '0;
            rsp_ff.divide_by_zero <= 1'b0;
         end else begin
            // zero divisor saturates and flags
            rsp_ff.loss           <= LOSS_MAX;
            rsp_ff.loss_fraction  <= FRACTION_MAX;
            rsp_ff.divide_by_zero <= (pop_data.magnitude == '0);
         end
      end else if (step) begin
         count_ff <= count_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         if (div_done) begin
            rsp_ff.loss          <= quo_in[DIVIDEND_W-1:FRACTION_W];
            rsp_ff.loss_fraction <= quo_in[FRACTION_W-1:0];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the class score loss accumulator.
// ----------------------------------------------------------------------------
// Scores go in through the req_ channel with random gaps. An in-bench model
// follows each vector and queues the loss beat it should end with. Every
// rsp_ beat is checked field by field against the oldest entry. Registers
// are only rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;
   import clsa_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE       = 2'd3;
   localparam logic [MODE_W-1:0]      MODE_WEIGHTED   = 2'd1;
   localparam logic [MODE_W-1:0]      MODE_NORMALISED = 2'd2;
   localparam logic [MODE_W-1:0]      MODE_RESERVED   = 2'd3;
   localparam int DRAIN_CYCLES  = 16;
   localparam int RANDOM_SCORES = 1720;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // register shadow
   logic [MODE_W-1:0]        cfg_mode      = MODE_PLAIN;
   logic [NUM_CLASSES_W-1:0] cfg_classes   = 7'd10;
   logic [MAGNITUDE_W-1:0]   cfg_magnitude = 11'd64;

   // running state of the vector in flight
   int                vec_pos        = 0;
   int                vec_true_class = 0;
   int                top_score      = 0;
   int                top_class      = 0;
   longint unsigned   vec_loss       = 0;
   longint unsigned   vec_magnitude  = 0;

   rsp_type pending_losses[$];
   int      errors          = 0;
   int      scores_sent     = 0;
   int      vectors_checked = 0;
   int      phases_run      = 0;
   int      hold_rsp        = 0;
   bit      no_idle         = 1'b0;

   class_score_loss_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(4_000_000);
      $display("tb: FAIL");
      $finish;
   end

   function automatic int idle_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int class_count(input logic [NUM_CLASSES_W-1:0] v);
      if (v < 2)
         return 2;
      if (v > MAX_CLASSES_DEFAULT)
         return MAX_CLASSES_DEFAULT;
      return int'(v);
   endfunction

   function automatic longint unsigned sat_add(input longint unsigned a, b, limit);
      if (a >= limit || b > limit - a)
         return limit;
      return a + b;
   endfunction

   // fold one accepted score into the vector, queue the loss beat on the last
   task automatic predict_vector_loss(input req_type item);
      int              s;
      int              n;
      int              goal;
      int              d;
      longint unsigned term;
      longint unsigned quot;
      rsp_type         want;
      s = $signed(item.score);
      n = class_count(cfg_classes);
      if (vec_pos == 0) begin
         vec_true_class = int'(item.true_class);
         top_score      = s;
         top_class      = 0;
         vec_loss       = 0;
         vec_magnitude  = 0;
      end else if (s > top_score) begin
         top_score = s;
         top_class = vec_pos;
      end
      goal = (vec_pos == vec_true_class) ? int'(cfg_magnitude) : -int'(cfg_magnitude);
      d = (goal > s) ? goal - s : s - goal;
      term = longint'(d) * longint'(d);
      if (cfg_mode != MODE_PLAIN && vec_pos == vec_true_class)
         term = term * longint'(n - 1);
      vec_loss      = sat_add(vec_loss, term, LOSS_MAX);
      vec_magnitude = sat_add(vec_magnitude, (s < 0) ? -s : s, MAGSUM_MAX);
      if (vec_pos + 1 < n) begin
         vec_pos++;
         return;
      end
      vec_pos = 0;
      want.loss            = vec_loss[LOSS_W-1:0];
      want.loss_fraction   = '0;
      want.predicted_class = CLASS_W'(top_class);
      want.correct         = (top_class == vec_true_class);
      want.divide_by_zero  = 1'b0;
      // division follows the mode seen on the last score
      if (cfg_mode[1]) begin
         if (vec_magnitude == 0) begin
            want.loss           = LOSS_MAX;
            want.loss_fraction  = FRACTION_MAX;
            want.divide_by_zero = 1'b1;
         end else begin
            quot = (vec_loss << FRACTION_W) / vec_magnitude;
            want.loss_fraction = quot[FRACTION_W-1:0];
            want.loss = ((quot >> FRACTION_W) > LOSS_MAX) ? LOSS_MAX
                                                          : LOSS_W'(quot >> FRACTION_W);
         end
      end
      pending_losses.push_back(want);
   endtask

   // valid is left high after the beat so the next one can follow back to back
   task automatic send_score(input req_type item);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_vector_loss(item);
      scores_sent++;
   endtask

   task automatic send_class_score(input int value, input int cls);
      req_type item;
      item.score      = SCORE_W'(value);
      item.true_class = CLASS_W'(cls);
      send_score(item);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_MODE:             cfg_mode      = value[MODE_W-1:0];
         CSR_NUM_CLASSES:      cfg_classes   = value[NUM_CLASSES_W-1:0];
         CSR_TARGET_MAGNITUDE: cfg_magnitude = value[MAGNITUDE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, let all loss beats come back, then give the pipe time to empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_losses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_vector(input int length);
      req_type item;
      int      n;
      int      kind;
      int      level;
      n     = class_count(cfg_classes);
      kind  = $urandom_range(0, 99);
      level = $urandom_range(0, 65535);
      for (int i = 0; i < length; i++) begin
         if (vec_pos == 0 && $urandom_range(0, 6) != 0)
            item.true_class = CLASS_W'($urandom_range(0, n - 1));
         else
            item.true_class = CLASS_W'($urandom);
         if (kind < 5) begin
            item.score = '0;
         end else if (kind < 15) begin
            item.score = SCORE_W'(level);
         end else if (kind < 25) begin
            case ($urandom_range(0, 3))
               0:       item.score = 16'sh8000;
               1:       item.score = 16'sh7fff;
               2:       item.score = 16'sh0000;
               default: item.score = 16'shffff;
            endcase
         end else if (kind < 60) begin
            item.score = SCORE_W'($urandom_range(0, 600) - 300);
         end else begin
            item.score = SCORE_W'($urandom);
         end
         send_score(item);
      end
   endtask

   task automatic test_default_vector();
      int vals[10] = '{32767, -32768, 0, 32767, -1, 1, 64, -64, 21845, -21846};
      // tie at the top between the first and fourth score, lowest index wins
      for (int i = 0; i < 10; i++)
         send_class_score(vals[i], (i == 0) ? 3 : $urandom_range(0, 63));
      settle();
   endtask

   task automatic test_modes_and_limits();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(2));
      write_reg(CSR_TARGET_MAGNITUDE, CSR_DATA_W'(2047));
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_WEIGHTED));
      send_class_score(-32768, 0);
      send_class_score(32767, 63);
      settle();
      // all scores zero leaves nothing to divide by
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_NORMALISED));
      send_class_score(0, 1);
      send_class_score(0, 0);
      settle();
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_RESERVED));
      send_class_score(1000, 0);
      send_class_score(-1000, 0);
      settle();
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_PLAIN));
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(0));
      write_reg(CSR_TARGET_MAGNITUDE, CSR_DATA_W'(0));
      write_reg(CSR_SPARE, {CSR_DATA_W{1'b1}});
      // true class beyond the vector, equal scores
      send_class_score(7, 63);
      send_class_score(7, 0);
      settle();
   endtask

   task automatic test_mid_vector_changes();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(5));
      write_reg(CSR_TARGET_MAGNITUDE, CSR_DATA_W'(100));
      send_class_score(120, 1);
      send_class_score(-40, 0);
      send_class_score(300, 0);
      settle();
      // position is already past the new count, next score closes the vector
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(2));
      send_class_score(-5, 0);
      settle();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(4));
      send_class_score(-200, 2);
      send_class_score(90, 0);
      settle();
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_NORMALISED));
      send_class_score(250, 0);
      send_class_score(-17, 0);
      settle();
   endtask

   task automatic test_output_stall();
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_PLAIN));
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(2));
      no_idle  = 1'b1;
      hold_rsp = 300;
      repeat (40)
         send_class_score($urandom_range(0, 65535), $urandom_range(0, 1));
      no_idle = 1'b0;
      settle();
   endtask

   task automatic test_random_phases();
      logic [CSR_DATA_W-1:0] data;
      int budget;
      int target;
      int pick;
      int n;
      int len;
      budget = 0;
      while (budget < RANDOM_SCORES) begin
         settle();
         data = CSR_DATA_W'($urandom);
         data[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
         write_reg(CSR_MODE, data);
         data = CSR_DATA_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            data[NUM_CLASSES_W-1:0] = NUM_CLASSES_W'($urandom_range(2, 8));
         else if (pick < 85)
            data[NUM_CLASSES_W-1:0] = NUM_CLASSES_W'($urandom_range(9, 20));
         else if (pick < 93)
            data[NUM_CLASSES_W-1:0] = NUM_CLASSES_W'(64);
         else if (pick < 97)
            data[NUM_CLASSES_W-1:0] = NUM_CLASSES_W'($urandom_range(0, 1));
         else
            data[NUM_CLASSES_W-1:0] = NUM_CLASSES_W'($urandom_range(65, 127));
         write_reg(CSR_NUM_CLASSES, data);
         pick = $urandom_range(0, 99);
         if (pick < 15)
            data = '0;
         else if (pick < 30)
            data = CSR_DATA_W'(1024);
         else if (pick < 40)
            data = {CSR_DATA_W{1'b1}};
         else if (pick < 80)
            data = CSR_DATA_W'($urandom_range(0, 1024));
         else
            data = CSR_DATA_W'($urandom);
         write_reg(CSR_TARGET_MAGNITUDE, data);
         no_idle = ($urandom_range(0, 3) == 0);
         n = class_count(cfg_classes);
         target = $urandom_range(40, 160);
         while (target > 0) begin
            len = n - vec_pos;
            if (len < 1)
               len = 1;
            // now and then a vector is cut short
            if ($urandom_range(0, 24) == 0)
               len = $urandom_range(1, len);
            if (len > target)
               len = target;
            send_random_vector(len);
            target -= len;
            budget += len;
         end
         phases_run++;
      end
      no_idle = 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin : drive_rsp_ready
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp > 0) begin
            rsp_ready <= 1'b0;
            hold_rsp--;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = ($urandom_range(0, 2) == 0) ? idle_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin : check_losses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_losses.size() == 0) begin
            $error("loss beat with nothing expected");
            errors++;
         end else begin
            want = pending_losses.pop_front();
            if (rsp_data.loss !== want.loss) begin
               $error("loss: expected %0d, got %0d", want.loss, rsp_data.loss);
               errors++;
            end
            if (rsp_data.loss_fraction !== want.loss_fraction) begin
               $error("loss_fraction: expected %0d, got %0d",
                      want.loss_fraction, rsp_data.loss_fraction);
               errors++;
            end
            if (rsp_data.predicted_class !== want.predicted_class) begin
               $error("predicted_class: expected %0d, got %0d",
                      want.predicted_class, rsp_data.predicted_class);
               errors++;
            end
            if (rsp_data.correct !== want.correct) begin
               $error("correct: expected %0d, got %0d", want.correct, rsp_data.correct);
               errors++;
            end
            if (rsp_data.divide_by_zero !== want.divide_by_zero) begin
               $error("divide_by_zero: expected %0d, got %0d",
                      want.divide_by_zero, rsp_data.divide_by_zero);
               errors++;
            end
            vectors_checked++;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_vector();
      test_modes_and_limits();
      test_mid_vector_changes();
      test_output_stall();
      test_random_phases();
      settle();
      $display("tb: %0d scores sent, %0d loss beats checked, %0d random register settings",
               scores_sent, vectors_checked, phases_run);
      $display("tb: all modes, zero divisor, argmax ties, class count limits, output hold-off");
      if (errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/clsa_pkg.sv
rtl/clsa_front.sv
rtl/clsa_queue.sv
rtl/clsa_back.sv
rtl/class_score_loss_accumulator.sv
bench/tb.sv
